FILE: rtl/tsel_pkg.sv
// Shared types and constants for the throughput rate selector.
// No dependencies; imported by every module of the block.
`default_nettype none

package tsel_pkg;

   // Field widths.
   localparam int DATA_W     = 32;  // speeds, estimates, byte counts, rates
   localparam int TIME_W     = 24;  // download time in milliseconds
   localparam int IDX_W      = 3;   // representation index and rate count
   localparam int CSR_IDX_W  = 3;   // configuration register index
   localparam int WGT_W      = 8;   // smoothing and scaling weights
   localparam int DIVIDEND_W = 40;  // byte_total * 250 needs 40 bits
   localparam int DIV_CNT_W  = 6;   // counts the serial division steps
   localparam int MOD3_W     = 2;   // running residue modulo three

   // Arithmetic constants.
   localparam logic [WGT_W-1:0]  SPEED_MUL  = 8'd250;  // bytes/ms to KiB/s in Q24.8
   localparam logic [WGT_W-1:0]  W_NEW      = 8'd77;   // weight of the new speed
   localparam logic [WGT_W-1:0]  W_OLD      = 8'd179;  // weight of the old estimate
   localparam logic [WGT_W-1:0]  SAFE_NUM   = 8'd230;  // safety margin, 230/256
   localparam int                RATE_SHIFT = 5;       // bit/s to KiB/s in Q24.8
   localparam logic [DATA_W-1:0] RESET_RATE = 32'd76800;
   localparam logic [DATA_W-1:0] SPEED_SAT  = '1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_BPS0  = 3'd1;

   // Sequencer states of the top level.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_SUM_SHORT,
      ST_SUM_LONG,
      ST_MIN,
      ST_THR,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Status returned by the serial divider.
   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] speed;
   } div_res_type;

   // Status returned by the rate scan.
   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] pick;
   } pick_res_type;

endpackage

`default_nettype wire

FILE: rtl/tsel_div.sv
// Bit-serial restoring divider that turns one download into a saturated speed.
// Depends on tsel_pkg for widths and the result struct.
`default_nettype none

module tsel_div
   import tsel_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DATA_W-1:0]     byte_total,
   input  wire logic [TIME_W-1:0]     time_ms,
   output      div_res_type           res
);

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIVIDEND_W - 1);

   logic                   busy_ff;
   logic                   done_ff;
   logic [DIV_CNT_W-1:0]   cnt_ff;
   logic [DIVIDEND_W-1:0]  num_ff;
   logic [TIME_W-1:0]      den_ff;
   logic [TIME_W-1:0]      rem_ff;

   logic [DIVIDEND_W-1:0]  dividend;
   logic [TIME_W+1:0]      trial;
   logic                   qbit;
   logic [TIME_W-1:0]      rem_in;

   assign dividend = DIVIDEND_W'(byte_total) * DIVIDEND_W'(SPEED_MUL);

   // One quotient bit per cycle: the next dividend bit enters the partial
   // remainder, and the divisor is taken off when it fits.
   always_comb begin
      trial  = {1'b0, rem_ff, num_ff[DIVIDEND_W-1]} - {2'b00, den_ff};
      qbit   = ~trial[TIME_W+1];
      rem_in = qbit ? trial[TIME_W-1:0] : {rem_ff[TIME_W-2:0], num_ff[DIVIDEND_W-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         den_ff <= time_ms;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[DIVIDEND_W-2:0], qbit};
         rem_ff <= rem_in;
      end
   end

   // A zero time or a quotient above 32 bits saturates.
   always_comb begin
      res.done = done_ff;
      if ((den_ff == '0) || (|num_ff[DIVIDEND_W-1:DATA_W])) begin
         res.speed = SPEED_SAT;
      end else begin
         res.speed = num_ff[DATA_W-1:0];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tsel_pick.sv
// Rate scan: visits one configured rate per cycle and keeps the best fit
// and the smallest rate. Depends on tsel_pkg.
`default_nettype none

module tsel_pick
   import tsel_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [IDX_W-1:0]    count,
   input  wire logic [DATA_W-1:0]   safe,
   input  wire logic [DATA_W-1:0]   rate_bps,
   output      logic [IDX_W-1:0]    rate_idx,
   output      pick_res_type        res
);

   logic                busy_ff;
   logic                done_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                found_ff;
   logic [IDX_W-1:0]    best_ff;
   logic [DATA_W-1:0]   best_rate_ff;
   logic [IDX_W-1:0]    min_idx_ff;
   logic [DATA_W-1:0]   min_rate_ff;

   logic [DATA_W-1:0]   rate;
   logic                take_best;
   logic                take_min;
   logic                last;

   always_comb begin
      rate      = rate_bps >> RATE_SHIFT;
      take_best = (rate <= safe) && (!found_ff || (rate > best_rate_ff));
      take_min  = (idx_ff == '0) || (rate < min_rate_ff);
      last      = (idx_ff == (count - 1'b1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && last) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else if (busy_ff) begin
         idx_ff <= idx_ff + 1'b1;
         if (take_best) begin
            found_ff     <= 1'b1;
            best_ff      <= idx_ff;
            best_rate_ff <= rate;
         end
         if (take_min) begin
            min_idx_ff  <= idx_ff;
            min_rate_ff <= rate;
         end
      end
   end

   assign rate_idx = idx_ff;
   assign res.done = done_ff;
   assign res.pick = found_ff ? best_ff : min_idx_ff;

endmodule

`default_nettype wire

FILE: rtl/throughput_rate_selector_unit.sv
// A report item runs the divider and, unless it is the first segment, the smoothing before
// the rate scan; a query-only item skips both and goes straight to the selection.
// The 40-step bit-serial divider and the one-rate-per-cycle scan set the time an item takes.
// One item is in work at a time; the next is accepted once the result is registered.
// Reset is synchronous and active high; it restores both estimates to 300 KiB/s, the choice to
// index 0, the rate count to 1 and all rates to zero.
`default_nettype none

// Top level of the throughput rate selector.
// Instantiates tsel_div and tsel_pick; uses types and constants from tsel_pkg.
module throughput_rate_selector_unit
   import tsel_pkg::*;
#(
   parameter int MAX_RATES = 6
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic                  req_query_only,
   input  wire logic [DATA_W-1:0]     req_byte_total,
   input  wire logic [TIME_W-1:0]     req_time_ms,
   input  wire logic [DATA_W-1:0]     req_segment_index,

   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [IDX_W-1:0]      rsp_chosen_index,
   output      logic                  rsp_switched,
   output      logic [DATA_W-1:0]     rsp_short_estimate,
   output      logic [DATA_W-1:0]     rsp_long_estimate,

   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [DATA_W-1:0]     csr_wdata
);

   localparam int RIDX_W = (MAX_RATES > 1) ? $clog2(MAX_RATES) : 1;

   // Control strobes decoded from the sequencer state.
   typedef struct packed {
      logic div_start;
      logic seg_shift;
      logic load_both;
      logic mul_new;
      logic sum_short;
      logic sum_long;
      logic take_min;
      logic scan_start;
      logic load_rsp;
   } ctl_type;

   state_type              state_ff;
   state_type              state_in;
   ctl_type                ctl;

   // Configuration registers.
   logic [IDX_W-1:0]       rate_count_ff;
   logic [DATA_W-1:0]      rate_bps_ff [MAX_RATES];

   // Item context and estimator state.
   logic                   seg_one_ff;
   logic [DATA_W-1:0]      seg_sr_ff;
   logic [MOD3_W-1:0]      mod3_ff;
   logic [MOD3_W-1:0]      mod3_in;
   logic [DIVIDEND_W-1:0]  prod_ff;
   logic [DATA_W-1:0]      short_ff;
   logic [DATA_W-1:0]      long_ff;
   logic [DATA_W-1:0]      lo_ff;
   logic [DATA_W-1:0]      safe_ff;
   logic [IDX_W-1:0]       choice_ff;

   // Result register.
   logic                   rsp_valid_ff;
   logic [IDX_W-1:0]       rsp_index_ff;
   logic                   rsp_switched_ff;
   logic [DATA_W-1:0]      rsp_short_ff;
   logic [DATA_W-1:0]      rsp_long_ff;

   logic                   accept;
   logic [IDX_W-1:0]       rate_n;
   logic [IDX_W-1:0]       scan_idx;
   logic [DIVIDEND_W-1:0]  sum_short;
   logic [DIVIDEND_W-1:0]  sum_long;
   logic [DIVIDEND_W-1:0]  safe_prod;
   div_res_type            div_res;
   pick_res_type           pick_res;

   // ------------------------------------------------------------------
   // Sequencer. The divider runs only for report items; a query-only item
   // goes straight to the selection.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_query_only ? ST_MIN : ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               state_in = seg_one_ff ? ST_MIN : ST_MUL;
            end
         end
         ST_MUL:       state_in = ST_SUM_SHORT;
         ST_SUM_SHORT: state_in = (mod3_ff == '0) ? ST_SUM_LONG : ST_MIN;
         ST_SUM_LONG:  state_in = ST_MIN;
         ST_MIN:       state_in = ST_THR;
         ST_THR:       state_in = ST_SCAN;
         ST_SCAN: begin
            if (pick_res.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            ctl.div_start = req_valid && !req_query_only;
         end
         ST_DIV: begin
            ctl.seg_shift = 1'b1;
            ctl.load_both = div_res.done && seg_one_ff;
         end
         ST_MUL:       ctl.mul_new    = 1'b1;
         ST_SUM_SHORT: ctl.sum_short  = 1'b1;
         ST_SUM_LONG:  ctl.sum_long   = 1'b1;
         ST_MIN:       ctl.take_min   = 1'b1;
         ST_THR:       ctl.scan_start = 1'b1;
         ST_SCAN:      ctl = '0;
         ST_DONE:      ctl.load_rsp   = !rsp_valid_ff || rsp_ready;
         default:      ctl = '0;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------
   // Configuration port. A write to a rate index beyond MAX_RATES, or to
   // an unused index, is dropped.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_count_ff <= IDX_W'(1);
         for (int k = 0; k < MAX_RATES; k++) begin
            rate_bps_ff[k] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == CSR_RATE_COUNT) begin
            rate_count_ff <= csr_wdata[IDX_W-1:0];
         end
         for (int k = 0; k < MAX_RATES; k++) begin
            if (csr_index == (CSR_RATE_BPS0 + CSR_IDX_W'(k))) begin
               rate_bps_ff[k] <= csr_wdata;
            end
         end
      end
   end

   // A count of zero acts as one, and a count above the table is clamped.
   always_comb begin
      if (rate_count_ff == '0) begin
         rate_n = IDX_W'(1);
      end else if (rate_count_ff > IDX_W'(MAX_RATES)) begin
         rate_n = IDX_W'(MAX_RATES);
      end else begin
         rate_n = rate_count_ff;
      end
   end

   // ------------------------------------------------------------------
   // Segment number: the first segment reloads both estimates. While the
   // divider runs, the segment number is shifted out MSB first and its
   // residue modulo three is built one bit a cycle. The zeros shifted in
   // after the last bit only double the residue, which keeps zero at zero.
   // ------------------------------------------------------------------
   always_comb begin
      case ({mod3_ff, seg_sr_ff[DATA_W-1]})
         3'b000:  mod3_in = 2'd0;
         3'b001:  mod3_in = 2'd1;
         3'b010:  mod3_in = 2'd2;
         3'b011:  mod3_in = 2'd0;
         3'b100:  mod3_in = 2'd1;
         3'b101:  mod3_in = 2'd2;
         default: mod3_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         seg_one_ff <= (req_segment_index == DATA_W'(1));
         seg_sr_ff  <= req_segment_index;
         mod3_ff    <= '0;
      end else if (ctl.seg_shift) begin
         seg_sr_ff <= {seg_sr_ff[DATA_W-2:0], 1'b0};
         mod3_ff   <= mod3_in;
      end
   end

   // ------------------------------------------------------------------
   // Speed and smoothing. The weighted new speed is formed once and used
   // by both estimates; each sum is 40 bits and keeps bits 39..8.
   // ------------------------------------------------------------------
   tsel_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (ctl.div_start),
      .byte_total (req_byte_total),
      .time_ms    (req_time_ms),
      .res        (div_res)
   );

   assign sum_short = prod_ff + DIVIDEND_W'(short_ff) * DIVIDEND_W'(W_OLD);
   assign sum_long  = prod_ff + DIVIDEND_W'(long_ff) * DIVIDEND_W'(W_OLD);
   assign safe_prod = DIVIDEND_W'(lo_ff) * DIVIDEND_W'(SAFE_NUM);

   always_ff @(posedge clock) begin
      if (ctl.mul_new) begin
         prod_ff <= DIVIDEND_W'(div_res.speed) * DIVIDEND_W'(W_NEW);
      end
      if (ctl.take_min) begin
         lo_ff <= (short_ff < long_ff) ? short_ff : long_ff;
      end
      if (ctl.scan_start) begin
         safe_ff <= safe_prod[DIVIDEND_W-1:DIVIDEND_W-DATA_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff <= RESET_RATE;
         long_ff  <= RESET_RATE;
      end else if (ctl.load_both) begin
         short_ff <= div_res.speed;
         long_ff  <= div_res.speed;
      end else begin
         if (ctl.sum_short) begin
            short_ff <= sum_short[DIVIDEND_W-1:DIVIDEND_W-DATA_W];
         end
         if (ctl.sum_long) begin
            long_ff <= sum_long[DIVIDEND_W-1:DIVIDEND_W-DATA_W];
         end
      end
   end

   // ------------------------------------------------------------------
   // Selection: the scan reads one rate per cycle from the table.
   // ------------------------------------------------------------------
   tsel_pick u_pick (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.scan_start),
      .count    (rate_n),
      .safe     (safe_ff),
      .rate_bps (rate_bps_ff[scan_idx[RIDX_W-1:0]]),
      .rate_idx (scan_idx),
      .res      (pick_res)
   );

   // ------------------------------------------------------------------
   // Result register. It holds a finished item until it is taken; the
   // choice is committed when the result is registered.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         choice_ff    <= '0;
      end else if (ctl.load_rsp) begin
         rsp_valid_ff <= 1'b1;
         choice_ff    <= pick_res.pick;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_rsp) begin
         rsp_index_ff    <= pick_res.pick;
         rsp_switched_ff <= (pick_res.pick != choice_ff);
         rsp_short_ff    <= short_ff;
         rsp_long_ff     <= long_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_chosen_index   = rsp_index_ff;
   assign rsp_switched       = rsp_switched_ff;
   assign rsp_short_estimate = rsp_short_ff;
   assign rsp_long_estimate  = rsp_long_ff;

endmodule

`default_nettype wire

FILE: rtl/tsel_chk.sv
// Port-level checker for the throughput rate selector, with its bind.
// Depends on tsel_pkg for widths; attaches to throughput_rate_selector_unit.
`default_nettype none

module tsel_chk
   import tsel_pkg::*;
#(
   parameter int MAX_RATES = 6
)
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [IDX_W-1:0]   rsp_chosen_index,
   input wire logic               rsp_switched,
   input wire logic [DATA_W-1:0]  rsp_short_estimate,
   input wire logic [DATA_W-1:0]  rsp_long_estimate
);

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Items are worked one at a time: an accepted item closes the input.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input still open after an item was accepted");

   // The chosen index always names a rate inside the table.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_chosen_index < IDX_W'(MAX_RATES)))
      else $error("chosen index outside the rate table");

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_chosen_index)
         && $stable(rsp_switched) && $stable(rsp_short_estimate)
         && $stable(rsp_long_estimate)))
      else $error("stalled result changed");

endmodule

bind throughput_rate_selector_unit tsel_chk #(.MAX_RATES(MAX_RATES)) u_tsel_chk (.*);

`default_nettype wire
